>>> rtl/core/bfrw_pkg.sv
// bfrw_pkg: shared constants for the MSB-first bit-field read/write block.
// No dependencies; imported by bit_field_read_write_top.
`default_nettype none

package bfrw_pkg;

   // byte store
   localparam int STORE_BYTES = 1024;
   localparam int ADDR_W      = $clog2(STORE_BYTES);

   // field widths
   localparam int BUF_W   = 11;   // buffer_bytes register
   localparam int INDEX_W = 16;
   localparam int LEN_W   = 6;
   localparam int DATA_W  = 32;
   localparam int STAT_W  = 2;
   localparam int FIELD_MAX = 32;

   // window of up to five bytes that one field can touch
   localparam int SPAN_BYTES = 5;
   localparam int WIN_W      = 8 * SPAN_BYTES;

   // operation codes
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK  = 2'd0;
   localparam logic [STAT_W-1:0] ST_NEG = 2'd1;
   localparam logic [STAT_W-1:0] ST_LEN = 2'd2;
   localparam logic [STAT_W-1:0] ST_END = 2'd3;

   // register map
   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-3:0] REG_BUFFER_BYTES = 1'b0;
   localparam logic [BUF_W-1:0] BUF_RESET = 11'd1024;

endpackage

`default_nettype wire

>>> rtl/core/bit_field_read_write_top.sv
// bit_field_read_write_top: bit-field extract/insert on a byte store, MSB first.
// Depends on bfrw_pkg.
//
//  channel | direction | beat contents
//  --------+-----------+---------------------------------------------------------
//  req_    | in        | tuser: operation; tdata: bit_index, field_length, write_value
//  rsp_    | out       | tdata: read_data, status
//  csr_    | in/out    | APB, one register: buffer_bytes at byte address 0
//
// An item goes through index adjustment, then the check, then one store read per byte
// touched (1..5) and the store's registered read, then the result beat; a failed
// access goes from the check straight to the result beat.
// The byte store has one write port and one registered read port (one read, one write a cycle).
// reset is synchronous; it clears control state, the store is not cleared.
// req_tready is low while an item is in flight; the result beat holds until taken.
`default_nettype none

module bit_field_read_write_top
   import bfrw_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request stream
   input  wire logic                   req_tvalid,
   output      logic                   req_tready,
   input  wire logic [55:0]            req_tdata,  // bit_index[15:0], field_length[21:16],
                                                   // write_value[53:22], zero[55:54]
   input  wire logic                   req_tuser,  // operation
   // response stream
   output      logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   output      logic [39:0]            rsp_tdata,  // read_data[31:0], status[33:32],
                                                   // zero[39:34]
   // register port
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [31:0]            csr_pwdata,
   output      logic [31:0]            csr_prdata,
   output      logic                   csr_pready
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_INDEX,
      S_CHECK,
      S_MEM,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   logic [BUF_W-1:0]    buf_ff, buf_in;
   logic                op_ff, op_in;
   logic [INDEX_W-1:0]  index_ff, index_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [DATA_W-1:0]   val_ff, val_in;

   logic [INDEX_W:0]    adj_ff, adj_in;      // signed, after negative adjustment
   logic [DATA_W-1:0]   mask_ff, mask_in;
   logic [DATA_W-1:0]   vmask_ff, vmask_in;
   logic                len_bad_ff, len_bad_in;

   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [2:0]          issue_ff, issue_in;
   logic [2:0]          proc_ff, proc_in;
   logic [2:0]          pad_ff, pad_in;
   logic [WIN_W-1:0]    wdat_ff, wdat_in;
   logic [WIN_W-1:0]    wmsk_ff, wmsk_in;
   logic [WIN_W-1:0]    acc_ff, acc_in;
   logic                rd_v_ff, rd_v_in;
   logic [ADDR_W-1:0]   rd_addr_ff, rd_addr_in;

   logic [DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [STAT_W-1:0]   rsp_status_ff, rsp_status_in;

   // byte store
   logic [7:0]          mem [STORE_BYTES];
   logic [7:0]          mem_rdata_ff;
   logic                mem_we;
   logic [ADDR_W-1:0]   mem_waddr;
   logic [7:0]          mem_wdata;

   logic [BUF_W-1:0]    nbytes;
   logic [INDEX_W-1:0]  end_bit;
   logic [2:0]          span;
   logic                csr_wr;
   logic                req_take;

   assign nbytes   = (buf_ff > BUF_W'(STORE_BYTES)) ? BUF_W'(STORE_BYTES) : buf_ff;
   assign end_bit  = adj_ff[INDEX_W-1:0] + {{(INDEX_W-LEN_W){1'b0}}, len_ff} - INDEX_W'(1);
   assign span     = end_bit[5:3] - adj_ff[5:3];

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1:2] == REG_BUFFER_BYTES) ?
                       {{(32-BUF_W){1'b0}}, buf_ff} : 32'd0;

   assign req_tready = (state_ff == S_IDLE);
   assign req_take   = req_tvalid & req_tready;
   assign rsp_tvalid = (state_ff == S_DONE);
   assign rsp_tdata  = {6'd0, rsp_status_ff, rsp_data_ff};

   always_comb begin
      state_in      = state_ff;
      buf_in        = buf_ff;
      op_in         = op_ff;
      index_in      = index_ff;
      len_in        = len_ff;
      val_in        = val_ff;
      adj_in        = adj_ff;
      mask_in       = mask_ff;
      vmask_in      = vmask_ff;
      len_bad_in    = len_bad_ff;
      addr_in       = addr_ff;
      issue_in      = issue_ff;
      proc_in       = proc_ff;
      pad_in        = pad_ff;
      wdat_in       = wdat_ff;
      wmsk_in       = wmsk_ff;
      acc_in        = acc_ff;
      rd_v_in       = 1'b0;
      rd_addr_in    = rd_addr_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      mem_waddr     = rd_addr_ff;
      mem_wdata     = (mem_rdata_ff & ~wmsk_ff[7:0]) | wdat_ff[7:0];

      if (csr_wr && csr_paddr[CSR_ADDR_W-1:2] == REG_BUFFER_BYTES) begin
         buf_in = csr_pwdata[BUF_W-1:0];
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               op_in    = req_tuser;
               index_in = req_tdata[15:0];
               len_in   = req_tdata[21:16];
               val_in   = req_tdata[53:22];
               state_in = S_INDEX;
            end
         end
         S_INDEX: begin
            adj_in = {index_ff[INDEX_W-1], index_ff} +
                     (index_ff[INDEX_W-1] ? {3'b000, nbytes, 3'b000} : '0);
            mask_in    = {DATA_W{1'b1}} >> (LEN_W'(FIELD_MAX) - len_ff);
            vmask_in   = val_ff & ({DATA_W{1'b1}} >> (LEN_W'(FIELD_MAX) - len_ff));
            len_bad_in = (len_ff == '0) || (len_ff > LEN_W'(FIELD_MAX));
            state_in   = S_CHECK;
         end
         S_CHECK: begin
            rsp_data_in = '0;
            pad_in      = 3'd7 - end_bit[2:0];
            wdat_in     = WIN_W'(vmask_ff) << (3'd7 - end_bit[2:0]);
            wmsk_in     = WIN_W'(mask_ff) << (3'd7 - end_bit[2:0]);
            acc_in      = '0;
            issue_in    = span + 3'd1;
            proc_in     = span + 3'd1;
            // writes walk from the last byte back so the window shifts right
            addr_in     = (op_ff == OP_WRITE) ? end_bit[ADDR_W+2:3] : adj_ff[ADDR_W+2:3];
            if (adj_ff[INDEX_W]) begin
               rsp_status_in = ST_NEG;
               state_in      = S_DONE;
            end else if (len_bad_ff) begin
               rsp_status_in = ST_LEN;
               state_in      = S_DONE;
            end else if ({2'b00, nbytes} <= end_bit[INDEX_W-1:3]) begin
               rsp_status_in = ST_END;
               state_in      = S_DONE;
            end else begin
               rsp_status_in = ST_OK;
               state_in      = S_MEM;
            end
         end
         S_MEM: begin
            if (issue_ff != '0) begin
               rd_v_in    = 1'b1;
               rd_addr_in = addr_ff;
               addr_in    = (op_ff == OP_WRITE) ? addr_ff - ADDR_W'(1) : addr_ff + ADDR_W'(1);
               issue_in   = issue_ff - 3'd1;
            end
            if (rd_v_ff) begin
               proc_in = proc_ff - 3'd1;
               if (op_ff == OP_WRITE) begin
                  mem_we  = 1'b1;
                  wdat_in = wdat_ff >> 8;
                  wmsk_in = wmsk_ff >> 8;
               end else begin
                  acc_in = {acc_ff[WIN_W-9:0], mem_rdata_ff};
               end
               if (proc_ff == 3'd1) begin
                  rsp_data_in = (op_ff == OP_WRITE) ? '0 :
                                DATA_W'({acc_ff[WIN_W-9:0], mem_rdata_ff} >> pad_ff) & mask_ff;
                  state_in    = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         buf_ff   <= BUF_RESET;
         rd_v_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         buf_ff   <= buf_in;
         rd_v_ff  <= rd_v_in;
      end
      op_ff         <= op_in;
      index_ff      <= index_in;
      len_ff        <= len_in;
      val_ff        <= val_in;
      adj_ff        <= adj_in;
      mask_ff       <= mask_in;
      vmask_ff      <= vmask_in;
      len_bad_ff    <= len_bad_in;
      addr_ff       <= addr_in;
      issue_ff      <= issue_in;
      proc_ff       <= proc_in;
      pad_ff        <= pad_in;
      wdat_ff       <= wdat_in;
      wmsk_ff       <= wmsk_in;
      acc_ff        <= acc_in;
      rd_addr_ff    <= rd_addr_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   // store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[addr_ff];
   end

   // checks
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request and response sides open together");

   a_write_gated: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_MEM && op_ff == OP_WRITE && rd_v_ff))
      else $error("store written outside a write access");

   a_zero_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_status_ff != ST_OK || op_ff == OP_WRITE)) |-> rsp_data_ff == '0)
      else $error("non-zero data on a write or failed access");

   a_issue_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MEM) |-> (issue_ff <= proc_ff))
      else $error("byte reads ran ahead of byte count");

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// tb_top: self-checking bench for bit_field_read_write_top, MSB-first field read/write.
// Depends on bfrw_pkg and the block's top level; the store image is filled before any read.
// Beats are predicted on acceptance and compared in order against the response stream.
module tb_top;
   import bfrw_pkg::*;

   localparam int QUIET_LIMIT = 3000;   // cycles without any accepted beat or register transfer
   localparam int DRAIN_WAIT  = 12;

   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic [STAT_W-1:0] status;
   } field_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [55:0]           req_tdata = '0;   // bit_index, field_length, write_value, zero pad
   logic                  req_tuser = 1'b0; // operation
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [39:0]           rsp_tdata;        // read_data, status, zero pad
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // predictor state
   logic [7:0]     store_image [STORE_BYTES];
   logic [BUF_W-1:0] buffer_len = BUF_RESET;
   field_result_type pending_results[$];
   int             mismatch_count = 0;
   int             quiet_cycles = 0;
   int             burst_left = 0;
   int             ready_mode = 0;
   int             ready_hold = 0;

   bit_field_read_write_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int used_bytes();
      return (buffer_len > STORE_BYTES) ? STORE_BYTES : int'(buffer_len);
   endfunction

   // Applies one access to the store image and returns the beat it should produce.
   function automatic field_result_type apply_field_access(logic op,
                                                           logic [INDEX_W-1:0] raw_idx,
                                                           logic [LEN_W-1:0] len,
                                                           logic [DATA_W-1:0] value);
      field_result_type r;
      int nbytes, idx, pos, k;
      r = '0;
      nbytes = used_bytes();
      idx = int'($signed(raw_idx));
      if (idx < 0) idx += nbytes * 8;
      if (idx < 0) begin
         r.status = ST_NEG;
      end else if (len == 0 || int'(len) > FIELD_MAX) begin
         r.status = ST_LEN;
      end else if (nbytes <= ((idx + int'(len) - 1) >> 3)) begin
         r.status = ST_END;
      end else begin
         r.status = ST_OK;
         for (k = 0; k < int'(len); k++) begin
            pos = idx + k;
            if (op == OP_READ)
               r.data = {r.data[DATA_W-2:0], store_image[pos >> 3][7 - (pos & 7)]};
            else
               store_image[pos >> 3][7 - (pos & 7)] = value[int'(len) - 1 - k];
         end
      end
      return r;
   endfunction

   // One request beat; valid stays high afterwards until the next call decides.
   task automatic issue_access(input logic op, input logic [INDEX_W-1:0] idx,
                               input logic [LEN_W-1:0] len, input logic [DATA_W-1:0] value);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, value, len, idx};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(apply_field_access(op, idx, len, value));
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_buffer_len(input logic [BUF_W-1:0] value);
      wait_idle();
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(4 * REG_BUFFER_BYTES);
      csr_pwdata  <= {21'($urandom), value};   // bits above the register are don't-care
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      buffer_len = value;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Whole store written first, so no later read touches an unwritten byte.
   task automatic test_fill_store();
      int i;
      for (i = 0; i < STORE_BYTES / 4; i++)
         issue_access(OP_WRITE, INDEX_W'(i * 32), LEN_W'(32), $urandom);
   endtask

   task automatic test_edges();
      write_buffer_len(11'd1024);
      issue_access(OP_READ,  16'd0,     6'd32, $urandom);
      issue_access(OP_READ,  16'd0,     6'd1,  $urandom);
      issue_access(OP_READ,  16'd8191,  6'd1,  $urandom);
      issue_access(OP_READ,  16'hFFFF,  6'd1,  $urandom);   // last bit via negative index
      issue_access(OP_READ,  -16'sd32,  6'd32, $urandom);
      issue_access(OP_WRITE, 16'd8160,  6'd32, 32'hFFFF_FFFF);
      issue_access(OP_READ,  16'd8160,  6'd32, 32'h0);
      issue_access(OP_WRITE, 16'd3,     6'd32, 32'hA5C3_0F96); // spans five bytes
      issue_access(OP_READ,  16'd3,     6'd32, 32'h0);
      issue_access(OP_READ,  16'd5,     6'd32, 32'h0);
      issue_access(OP_WRITE, 16'd7,     6'd1,  32'h0);
      issue_access(OP_WRITE, 16'd8,     6'd1,  32'hFFFF_FFFF);
      issue_access(OP_READ,  16'd0,     6'd16, 32'h0);
      issue_access(OP_WRITE, 16'h8000,  6'd8,  32'hFFFF_FFFF); // far negative
      issue_access(OP_READ,  16'h7FFF,  6'd1,  32'h0);
      issue_access(OP_READ,  16'd0,     6'd0,  32'h0);
      issue_access(OP_READ,  16'd0,     6'd33, 32'h0);
      issue_access(OP_READ,  16'd0,     6'd63, 32'h0);
      issue_access(OP_READ,  16'h8000,  6'd0,  32'h0);  // index fault wins over length
      issue_access(OP_READ,  16'h7FFF,  6'd40, 32'h0);  // length fault wins over end
      issue_access(OP_WRITE, 16'd8161,  6'd32, 32'h1234_5678);
      issue_access(OP_READ,  16'd8160,  6'd32, 32'h0);  // failed write left nothing behind
      issue_access(OP_READ,  -16'sd8192, 6'd32, 32'h0);
      issue_access(OP_READ,  -16'sd8193, 6'd32, 32'h0);
      issue_access(OP_WRITE, 16'd0,     6'd0,  32'hFFFF_FFFF);
   endtask

   task automatic test_random_traffic(input int n_items);
      int span, len, pos, pick;
      logic [INDEX_W-1:0] idx;
      logic [LEN_W-1:0] len_f;
      span = used_bytes() * 8;
      repeat (n_items) begin
         pick = $urandom_range(0, 99);
         if (span > 0 && pick < 85) begin
            len = ($urandom_range(0, 3) == 0) ? ((span < 32) ? span : 32)
                                              : $urandom_range(1, (span < 32) ? span : 32);
            pos = $urandom_range(0, span - len);
            idx = ($urandom_range(0, 2) == 0) ? INDEX_W'(pos - span) : INDEX_W'(pos);
            len_f = LEN_W'(len);
         end else begin
            case (pick % 4)
               0: begin
                  idx   = INDEX_W'($urandom);
                  len_f = LEN_W'($urandom);
               end
               1: begin   // runs past the end
                  len   = $urandom_range(1, 32);
                  idx   = INDEX_W'(span - len + $urandom_range(1, 40));
                  len_f = LEN_W'(len);
               end
               2: begin
                  idx   = INDEX_W'($urandom_range(0, (span > 0) ? span - 1 : 0));
                  len_f = ($urandom_range(0, 3) == 0) ? '0 : LEN_W'($urandom_range(33, 63));
               end
               default: begin   // still negative after the wrap
                  idx   = INDEX_W'(-span - $urandom_range(1, 32768 - span));
                  len_f = LEN_W'($urandom_range(1, 32));
               end
            endcase
         end
         issue_access(logic'($urandom_range(0, 1)), idx, len_f, $urandom);
      end
   endtask

   task automatic test_empty_buffer();
      write_buffer_len(11'd0);
      issue_access(OP_READ,  16'hFFFF, 6'd1,  32'h0);
      issue_access(OP_READ,  16'd0,    6'd1,  32'h0);
      issue_access(OP_READ,  16'd0,    6'd0,  32'h0);
      issue_access(OP_WRITE, 16'd0,    6'd32, 32'hFFFF_FFFF);
      issue_access(OP_READ,  16'h7FFF, 6'd63, 32'h0);
      test_random_traffic(30);
   endtask

   task automatic test_oversize_buffer();
      write_buffer_len(11'd2047);   // saturates to the full store
      issue_access(OP_READ,  16'hFFFF,   6'd1,  32'h0);
      issue_access(OP_WRITE, -16'sd32,   6'd32, $urandom);
      issue_access(OP_READ,  -16'sd32,   6'd32, 32'h0);
      issue_access(OP_READ,  16'd8161,   6'd32, 32'h0);
      test_random_traffic(40);
      write_buffer_len(11'd1025);
      test_random_traffic(40);
   endtask

   task automatic test_buffer_sweep();
      write_buffer_len(11'd1024);
      test_random_traffic(100);
      write_buffer_len(11'd1);
      test_random_traffic(40);
      write_buffer_len(11'd5);
      test_random_traffic(40);
      write_buffer_len(BUF_W'($urandom_range(2, 1023)));
      test_random_traffic(100);
      write_buffer_len(11'd37);
      test_random_traffic(40);
      write_buffer_len(11'd1024);
      test_random_traffic(80);
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      test_fill_store();
      test_edges();
      test_empty_buffer();
      test_oversize_buffer();
      test_buffer_sweep();
      wait_idle();
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // response stall pattern, independent of the sender
   always @(negedge clock) begin
      if (ready_hold == 0) begin
         ready_mode <= $urandom_range(0, 2);
         ready_hold <= $urandom_range(20, 80);
      end else begin
         ready_hold <= ready_hold - 1;
      end
      case (ready_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= ($urandom_range(0, 1) == 1);
         default: rsp_tready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   always @(posedge clock) begin
      field_result_type exp_beat;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected beat, actual data %h status %0d",
                     $time, rsp_tdata[31:0], rsp_tdata[33:32]);
            mismatch_count++;
         end else begin
            exp_beat = pending_results.pop_front();
            if (rsp_tdata[31:0] !== exp_beat.data) begin
               $display("%0t: read_data expected %h actual %h",
                        $time, exp_beat.data, rsp_tdata[31:0]);
               mismatch_count++;
            end
            if (rsp_tdata[33:32] !== exp_beat.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, exp_beat.status, rsp_tdata[33:32]);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: watchdog expired", $time);
         $display("Mismatches found");
         $finish;
      end
   end

endmodule

>>> files.f
rtl/core/bfrw_pkg.sv
rtl/core/bit_field_read_write_top.sv
tb/sv/tb_top.sv
